// File: src/assert_macros.svh
// Assertion helpers used by the checker file rta_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define RTA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked on every clock edge, reset included.
`define RTA_ASSERT_NR(label, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// File: src/rta_pkg.sv
`default_nettype none

package rta_pkg;

    typedef enum logic [2:0] {
        FN_ADD_DIRECT  = 3'd0,
        FN_ADD_VIA     = 3'd1,
        FN_REMOVE_DEST = 3'd2,
        FN_REMOVE_VIA  = 3'd3,
        FN_LOOKUP      = 3'd4
    } rta_func_t;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    localparam logic [15:0] MAX_AGE_RESET = 16'd600;
    localparam logic [10:0] HANDLE_NONE   = 11'h7FF;

    typedef struct packed {
        logic [31:0] dest;
        logic [31:0] hop;
        logic        direct;
        logic [10:0] handle;
        logic [7:0]  metric;
        logic [31:0] stamp;
    } rta_entry_t;

    // compare results for one table entry
    typedef struct packed {
        logic dest_eq;
        logic hop_eq;
        logic stale;
    } rta_match_t;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_EVAL = 5'b00100,
        S_COPY = 5'b01000,
        S_DONE = 5'b10000
    } rta_state_t;

endpackage

`default_nettype wire

// File: src/rta_mem.sv
`default_nettype none

module rta_mem #(
    parameter int DEPTH = 64
) (
    input  wire logic                      clk,
    input  wire logic                      wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]  wr_addr,
    input  wire rta_pkg::rta_entry_t       wr_data,
    input  wire logic                      rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]  rd_addr,
    output rta_pkg::rta_entry_t            rd_data
);

    rta_pkg::rta_entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: src/rta_match.sv
`default_nettype none

module rta_match (
    input  wire rta_pkg::rta_entry_t entry,
    input  wire logic [31:0]       node,
    input  wire logic [31:0]       cmp_hop,
    input  wire logic [31:0]       now,
    input  wire logic [15:0]       max_age,
    output rta_pkg::rta_match_t    result
);

    logic [31:0] age;

    // age wraps modulo 2^32
    assign age = now - entry.stamp;

    assign result.dest_eq = (entry.dest == node);
    assign result.hop_eq  = (entry.hop == cmp_hop);
    assign result.stale   = !entry.direct && (age > {16'd0, max_age});

endmodule

`default_nettype wire

// File: src/route_table_with_aging.sv
// Operation: each table entry examined passes through S_READ and S_EVAL; after the scan
//   S_DONE loads the output register. A removal hit that moves the last entry into the
//   hole adds an S_COPY step before that slot is checked again.
// Flow: one item at a time; the single memory read port sets the pace.
//   A new item is taken once the result sits in the output register.
// Reset: entry count cleared, max_age_reg 600; table contents are not cleared.
`default_nettype none

module route_table_with_aging #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [15:0]        cfg_data,

    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire logic [2:0]         func,
    input  wire logic [31:0]        node_id,
    input  wire logic [31:0]        next_hop_id,
    input  wire logic signed [10:0] link_handle,
    input  wire logic [7:0]         hop_metric,
    input  wire logic [31:0]        now_seconds,

    output logic                    result_valid,
    input  wire logic               result_stall,
    output logic [1:0]              status,
    output logic [31:0]             route_next_hop,
    output logic                    route_is_direct,
    output logic signed [10:0]      route_link_handle,
    output logic [7:0]              route_hop_count
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

    rta_pkg::rta_state_t state_reg, state_next;

    logic [2:0]        func_reg;
    logic [31:0]       node_reg;
    logic [31:0]       hop_reg;
    logic [10:0]       handle_reg;
    logic [7:0]        dist_reg;
    logic [31:0]       now_reg;
    logic [15:0]       max_age_reg;

    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  last_idx;
    logic              any_reg, any_next;

    logic [1:0]        res_status_reg, res_status_next;
    logic [31:0]       res_hop_reg, res_hop_next;
    logic              res_direct_reg, res_direct_next;
    logic [10:0]       res_handle_reg, res_handle_next;
    logic [7:0]        res_dist_reg, res_dist_next;

    logic              out_valid_reg;
    logic              out_load;

    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    rta_pkg::rta_entry_t  rd_data;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    rta_pkg::rta_entry_t  wr_data;
    rta_pkg::rta_entry_t  new_entry;

    logic                 is_add_direct;
    logic [31:0]          cmp_hop;
    rta_pkg::rta_match_t  match;

    assign cfg_ready    = 1'b1;
    assign item_stall   = (state_reg != rta_pkg::S_IDLE);
    assign result_valid = out_valid_reg;

    assign is_add_direct = (func_reg == rta_pkg::FN_ADD_DIRECT);
    assign cmp_hop       = is_add_direct ? node_reg : hop_reg;
    assign last_idx      = CNT_W'(cnt_reg - 1'b1);
    assign out_load      = (state_reg == rta_pkg::S_DONE) && (!out_valid_reg || !result_stall);

    always_comb
    begin
        new_entry.dest   = node_reg;
        new_entry.hop    = cmp_hop;
        new_entry.direct = is_add_direct;
        new_entry.handle = is_add_direct ? handle_reg : rta_pkg::HANDLE_NONE;
        new_entry.metric = is_add_direct ? 8'd1 : dist_reg;
        new_entry.stamp  = now_reg;
    end

    rta_mem #(
        .DEPTH (TABLE_DEPTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rta_match u_match (
        .entry   (rd_data),
        .node    (node_reg),
        .cmp_hop (cmp_hop),
        .now     (now_reg),
        .max_age (max_age_reg),
        .result  (match)
    );

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        any_next        = any_reg;
        res_status_next = res_status_reg;
        res_hop_next    = res_hop_reg;
        res_direct_next = res_direct_reg;
        res_handle_next = res_handle_reg;
        res_dist_next   = res_dist_reg;
        rd_en           = 1'b0;
        rd_addr         = idx_reg[IDX_W-1:0];
        wr_en           = 1'b0;
        wr_addr         = idx_reg[IDX_W-1:0];
        wr_data         = rd_data;

        unique case (state_reg)
            rta_pkg::S_IDLE:
            begin
                if (item_valid)
                begin
                    idx_next        = '0;
                    any_next        = 1'b0;
                    res_status_next = rta_pkg::ST_OK;
                    res_hop_next    = '0;
                    res_direct_next = 1'b0;
                    res_handle_next = '0;
                    res_dist_next   = '0;
                    // unused selectors answer ok at once
                    state_next = (func > rta_pkg::FN_LOOKUP) ? rta_pkg::S_DONE
                                                             : rta_pkg::S_READ;
                end
            end

            rta_pkg::S_READ:
            begin
                if (idx_reg < cnt_reg)
                begin
                    rd_en      = 1'b1;
                    state_next = rta_pkg::S_EVAL;
                end
                else
                begin
                    state_next = rta_pkg::S_DONE;
                    unique case (func_reg)
                        rta_pkg::FN_ADD_DIRECT, rta_pkg::FN_ADD_VIA:
                        begin
                            if (cnt_reg == FULL_COUNT)
                            begin
                                res_status_next = rta_pkg::ST_FULL;
                            end
                            else
                            begin
                                wr_en    = 1'b1;
                                wr_addr  = cnt_reg[IDX_W-1:0];
                                wr_data  = new_entry;
                                cnt_next = CNT_W'(cnt_reg + 1'b1);
                            end
                        end
                        rta_pkg::FN_REMOVE_DEST:
                        begin
                            res_status_next = any_reg ? rta_pkg::ST_OK
                                                      : rta_pkg::ST_NOT_FOUND;
                        end
                        rta_pkg::FN_LOOKUP:
                        begin
                            res_status_next = rta_pkg::ST_NOT_FOUND;
                        end
                        default:
                        begin
                            res_status_next = rta_pkg::ST_OK;
                        end
                    endcase
                end
            end

            rta_pkg::S_EVAL:
            begin
                idx_next   = CNT_W'(idx_reg + 1'b1);
                state_next = rta_pkg::S_READ;
                unique case (func_reg)
                    rta_pkg::FN_ADD_DIRECT:
                    begin
                        if (match.dest_eq && match.hop_eq)
                        begin
                            wr_en          = 1'b1;
                            wr_data.direct = 1'b1;
                            wr_data.handle = handle_reg;
                            wr_data.metric = 8'd1;
                            wr_data.stamp  = now_reg;
                            idx_next       = idx_reg;
                            state_next     = rta_pkg::S_DONE;
                        end
                    end
                    rta_pkg::FN_ADD_VIA:
                    begin
                        if (match.dest_eq && match.hop_eq)
                        begin
                            // a direct route wins over the via refresh
                            wr_en          = !rd_data.direct;
                            wr_data.metric = dist_reg;
                            wr_data.stamp  = now_reg;
                            idx_next       = idx_reg;
                            state_next     = rta_pkg::S_DONE;
                        end
                    end
                    rta_pkg::FN_REMOVE_DEST, rta_pkg::FN_REMOVE_VIA:
                    begin
                        if ((func_reg == rta_pkg::FN_REMOVE_DEST) ? match.dest_eq
                            : (!rd_data.direct && match.hop_eq))
                        begin
                            any_next = 1'b1;
                            cnt_next = last_idx;
                            idx_next = idx_reg;
                            // fill the hole with the last entry, then recheck it
                            if (idx_reg < last_idx)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = last_idx[IDX_W-1:0];
                                state_next = rta_pkg::S_COPY;
                            end
                        end
                    end
                    rta_pkg::FN_LOOKUP:
                    begin
                        if (match.dest_eq && !match.stale)
                        begin
                            res_status_next = rta_pkg::ST_OK;
                            res_hop_next    = rd_data.hop;
                            res_direct_next = rd_data.direct;
                            res_handle_next = rd_data.handle;
                            res_dist_next   = rd_data.metric;
                            state_next      = rta_pkg::S_DONE;
                        end
                    end
                    default:
                    begin
                        state_next = rta_pkg::S_DONE;
                    end
                endcase
            end

            rta_pkg::S_COPY:
            begin
                wr_en      = 1'b1;
                state_next = rta_pkg::S_READ;
            end

            rta_pkg::S_DONE:
            begin
                if (out_load)
                begin
                    state_next = rta_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = rta_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rta_pkg::S_IDLE;
            cnt_reg       <= '0;
            max_age_reg   <= rta_pkg::MAX_AGE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_valid && cfg_ready)
            begin
                max_age_reg <= cfg_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            func_reg   <= func;
            node_reg   <= node_id;
            hop_reg    <= next_hop_id;
            handle_reg <= link_handle;
            dist_reg   <= hop_metric;
            now_reg    <= now_seconds;
        end
        idx_reg        <= idx_next;
        any_reg        <= any_next;
        res_status_reg <= res_status_next;
        res_hop_reg    <= res_hop_next;
        res_direct_reg <= res_direct_next;
        res_handle_reg <= res_handle_next;
        res_dist_reg   <= res_dist_next;
        if (out_load)
        begin
            status            <= res_status_reg;
            route_next_hop    <= res_hop_reg;
            route_is_direct   <= res_direct_reg;
            route_link_handle <= res_handle_reg;
            route_hop_count   <= res_dist_reg;
        end
    end

endmodule

`default_nettype wire

// File: src/rta_checker.sv
`default_nettype none
`include "assert_macros.svh"

module rta_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               item_valid,
    input wire logic               item_stall,
    input wire logic               result_valid,
    input wire logic               result_stall,
    input wire logic [1:0]         status,
    input wire logic [31:0]        route_next_hop,
    input wire logic               route_is_direct,
    input wire logic signed [10:0] route_link_handle,
    input wire logic [7:0]         route_hop_count
);

    // one item in flight: the input closes right after a transfer
    `RTA_ASSERT(a_busy_after_accept, item_valid && !item_stall |=> item_stall, "input not closed after transfer")

    `RTA_ASSERT(a_result_holds, result_valid && result_stall |=> result_valid && $stable(status) && $stable(route_next_hop), "stalled result changed")

    // misses and table-full carry no route
    `RTA_ASSERT(a_miss_no_route, result_valid && status != rta_pkg::ST_OK |-> route_next_hop == 32'd0 && !route_is_direct && route_link_handle == 11'sd0 && route_hop_count == 8'd0, "route fields set without a hit")

    // direct routes are always one hop
    `RTA_ASSERT(a_direct_one_hop, result_valid && route_is_direct |-> route_hop_count == 8'd1 && status == rta_pkg::ST_OK, "direct route with bad hop count")

    `RTA_ASSERT_NR(a_quiet_after_reset, !rst_n |=> !result_valid, "result shortly after reset")

endmodule

bind route_table_with_aging rta_checker u_rta_checker (.*);

`default_nettype wire
